### rtl/core/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  localparam int RES_MAX = 4;
  localparam int CNT_W = 3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE = 3'd0;
  localparam logic [2:0] ERR_UNTERM = 3'd1;
  localparam logic [2:0] ERR_CTRL = 3'd2;
  localparam logic [2:0] ERR_ESC = 3'd3;
  localparam logic [2:0] ERR_HEX = 3'd4;
  localparam logic [2:0] ERR_NO_LOW = 3'd5;
  localparam logic [2:0] ERR_BAD_LOW = 3'd6;
  localparam logic [2:0] ERR_LONE_LOW = 3'd7;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] hex_value;
    logic [1:0]  hex_count;
    logic [9:0]  high_half;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/jsu_step.sv
`default_nettype none
module jsu_step import jsu_pkg::*; (
  input  wire logic [7:0]       c,
  input  wire dec_state_t       cur,
  output dec_state_t            nxt,
  output res_t                  res [RES_MAX],
  output logic [CNT_W-1:0]      n
);

  localparam logic [3:0] PH_WAIT = 4'd0;
  localparam logic [3:0] PH_BODY = 4'd1;
  localparam logic [3:0] PH_ESC = 4'd2;
  localparam logic [3:0] PH_HEX1 = 4'd3;
  localparam logic [3:0] PH_NEED_BS = 4'd4;
  localparam logic [3:0] PH_NEED_U = 4'd5;
  localparam logic [3:0] PH_HEX2 = 4'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  logic        is_err;
  logic [2:0]  code;
  logic        single;
  logic [7:0]  single_byte;
  logic [1:0]  single_kind;
  logic        emit;
  logic [20:0] cp;
  logic [4:0]  hx;
  logic [15:0] hv;

  always_comb begin
    nxt = cur;
    is_err = 1'b0;
    code = ERR_NO_QUOTE;
    single = 1'b0;
    single_byte = 8'd0;
    single_kind = KIND_DATA;
    emit = 1'b0;
    cp = 21'd0;
    hx = hex_of(c);
    hv = {cur.hex_value[11:0], hx[3:0]};
    n = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '0;
    end

    case (cur.phase)
      PH_WAIT: begin
        if (c == CH_QUOTE) begin
          nxt.phase = PH_BODY;
        end else begin
          is_err = 1'b1;
          code = ERR_NO_QUOTE;
        end
      end
      PH_BODY: begin
        if (c == CH_QUOTE) begin
          nxt.phase = PH_WAIT;
          single = 1'b1;
          single_kind = KIND_DONE;
        end else if (c == 8'h00) begin
          is_err = 1'b1;
          code = ERR_UNTERM;
        end else if (c < 8'h20) begin
          is_err = 1'b1;
          code = ERR_CTRL;
        end else if (c == CH_BSLASH) begin
          nxt.phase = PH_ESC;
        end else begin
          single = 1'b1;
          single_byte = c;
        end
      end
      PH_ESC: begin
        nxt.phase = PH_BODY;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            single = 1'b1;
            single_byte = c;
          end
          CH_B: begin
            single = 1'b1;
            single_byte = 8'h08;
          end
          CH_F: begin
            single = 1'b1;
            single_byte = 8'h0C;
          end
          CH_N: begin
            single = 1'b1;
            single_byte = 8'h0A;
          end
          CH_R: begin
            single = 1'b1;
            single_byte = 8'h0D;
          end
          CH_T: begin
            single = 1'b1;
            single_byte = 8'h09;
          end
          CH_U: begin
            nxt.phase = PH_HEX1;
            nxt.hex_value = 16'd0;
            nxt.hex_count = 2'd0;
          end
          default: begin
            is_err = 1'b1;
            code = ERR_ESC;
          end
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (!hx[4]) begin
          is_err = 1'b1;
          code = (cur.phase == PH_HEX1) ? ERR_HEX : ERR_BAD_LOW;
        end else if (cur.hex_count != 2'd3) begin
          nxt.hex_value = hv;
          nxt.hex_count = cur.hex_count + 2'd1;
        end else begin
          nxt.hex_value = 16'd0;
          nxt.hex_count = 2'd0;
          if (cur.phase == PH_HEX1) begin
            if (hv[15:10] == 6'b110110) begin
              nxt.high_half = hv[9:0];
              nxt.phase = PH_NEED_BS;
            end else if (hv[15:10] == 6'b110111) begin
              is_err = 1'b1;
              code = ERR_LONE_LOW;
            end else begin
              emit = 1'b1;
              cp = {5'd0, hv};
            end
          end else begin
            if (hv[15:10] != 6'b110111) begin
              is_err = 1'b1;
              code = ERR_BAD_LOW;
            end else begin
              emit = 1'b1;
              cp = {11'({1'b0, cur.high_half}) + 11'd64, hv[9:0]};
            end
          end
        end
      end
      PH_NEED_BS: begin
        if (c == CH_BSLASH) begin
          nxt.phase = PH_NEED_U;
        end else begin
          is_err = 1'b1;
          code = ERR_NO_LOW;
        end
      end
      PH_NEED_U: begin
        if (c == CH_U) begin
          nxt.phase = PH_HEX2;
          nxt.hex_value = 16'd0;
          nxt.hex_count = 2'd0;
        end else begin
          is_err = 1'b1;
          code = ERR_NO_LOW;
        end
      end
      default: begin
        nxt.phase = PH_WAIT;
      end
    endcase

    if (is_err) begin
      nxt.phase = PH_WAIT;
      nxt.hex_value = 16'd0;
      nxt.hex_count = 2'd0;
      res[0].kind = KIND_ERR;
      res[0].error_code = code;
      n = CNT_W'(1);
    end else if (single) begin
      res[0].out_byte = single_byte;
      res[0].kind = single_kind;
      n = CNT_W'(1);
    end else if (emit) begin
      nxt.phase = PH_BODY;
      if (cp < 21'h80) begin
        res[0].out_byte = cp[7:0];
        n = CNT_W'(1);
      end else if (cp < 21'h800) begin
        res[0].out_byte = {3'b110, cp[10:6]};
        res[1].out_byte = {2'b10, cp[5:0]};
        n = CNT_W'(2);
      end else if (cp < 21'h10000) begin
        res[0].out_byte = {4'b1110, cp[15:12]};
        res[1].out_byte = {2'b10, cp[11:6]};
        res[2].out_byte = {2'b10, cp[5:0]};
        n = CNT_W'(3);
      end else begin
        res[0].out_byte = {5'b11110, cp[20:18]};
        res[1].out_byte = {2'b10, cp[17:12]};
        res[2].out_byte = {2'b10, cp[11:6]};
        res[3].out_byte = {2'b10, cp[5:0]};
        n = CNT_W'(4);
      end
    end

    for (int i = 0; i < RES_MAX; i++) begin
      res[i].last = (CNT_W'(i + 1) == n);
    end
  end

endmodule
`default_nettype wire

### rtl/core/jsu_obuf.sv
`default_nettype none
module jsu_obuf import jsu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire res_t             load_res [RES_MAX],
  input  wire logic [CNT_W-1:0] load_n,
  output logic                  can_load,
  output res_t                  head,
  output logic                  head_valid,
  input  wire logic             head_ready,
  output logic [CNT_W-1:0]      count
);

  res_t             slots [RES_MAX];
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign head_valid = (count != '0);
  assign head = slots[0];
  assign pop = head_valid && head_ready;
  assign can_load = (count == '0) || ((count == CNT_W'(1)) && pop);

  always_comb begin
    count_next = count;
    if (load) begin
      count_next = load_n;
    end else if (pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_res;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        slots[i] <= slots[i + 1];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
// Results of an item appear in the cycle after it is accepted.
// Throughput: one item per cycle while out_ready is high; an item that yields k results holds
// the input while the result buffer drains one per cycle as out_ready allows.
// Reset (rst, synchronous, active high) returns to waiting for the opening
// quote and empties the result buffer.
`default_nettype none
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic [2:0]      error_code,
  output logic            last
);

  dec_state_t       state;
  dec_state_t       state_next;
  res_t             step_res [RES_MAX];
  logic [CNT_W-1:0] step_n;
  logic             accept;
  res_t             head;
  logic [CNT_W-1:0] count;

  jsu_step u_step (
    .c   (in_byte),
    .cur (state),
    .nxt (state_next),
    .res (step_res),
    .n   (step_n)
  );

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  jsu_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_res   (step_res),
    .load_n     (step_n),
    .can_load   (in_ready),
    .head       (head),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .count      (count)
  );

  assign out_byte = head.out_byte;
  assign kind = head.kind;
  assign error_code = head.error_code;
  assign last = head.last;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_MAX)) else $error("result count overflow");
  a_last_one: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(1)) |-> last) else $error("final item not marked last");
  a_last_more: assert property (@(posedge clk) disable iff (rst)
    (count > CNT_W'(1)) |-> !last) else $error("last marked too early");
  a_ctrl_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> (last && out_byte == 8'd0))
    else $error("completion or error not a single item");
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    (in_ready && !out_valid) |=> !(out_valid && count > CNT_W'(RES_MAX)))
    else $error("buffer state after load inconsistent");
`endif

endmodule
`default_nettype wire
